FILE: hdl/ols_pkg.sv
// Shared types and codes for the ordered list store.
// No dependencies; imported by every module of the block.
package ols_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RM_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RM_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RM_POS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

endpackage

FILE: hdl/ols_mem.sv
// Entry storage: one write port, one read port with registered read data.
// Depends on ols_pkg.
module ols_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  ols_pkg::mem_req_t         req,
  input  logic [AW-1:0]             wr_addr,
  input  logic [AW-1:0]             rd_addr,
  output logic [ols_pkg::DATA_W-1:0] rd_data
);
  import ols_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ols_ctrl.sv
// Command sequencer: decodes a beat, shifts entries one slot per step,
// walks the list for listing, and owns the result register.
// Depends on ols_pkg; drives ols_mem.
module ols_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ols_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [ols_pkg::DATA_W-1:0]  in_value,
  input  logic [ols_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ols_pkg::STATUS_W-1:0]       out_status,
  output logic signed [ols_pkg::DATA_W-1:0]  out_item,
  output logic                               out_item_valid,
  output logic                               out_last,
  output ols_pkg::mem_req_t                  mem_req,
  output logic [AW-1:0]                      mem_wr_addr,
  output logic [AW-1:0]                      mem_rd_addr,
  input  logic [ols_pkg::DATA_W-1:0]         mem_rd_data
);
  import ols_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LIST_RD,
    S_LIST_OUT,
    S_STATUS
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [DATA_W-1:0]    out_item_r, out_item_nxt;
  logic                 out_item_valid_r, out_item_valid_nxt;
  logic                 out_last_r, out_last_nxt;

  logic can_emit;
  logic pos_ok;
  logic list_last;

  assign can_emit  = !out_valid_r || out_ready;
  assign pos_ok    = (in_position != '0) && (in_position <= POS_W'(count_r));
  assign list_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    idx_nxt            = idx_r;
    status_nxt         = status_r;
    out_valid_nxt      = out_valid_r;
    out_status_nxt     = out_status_r;
    out_item_nxt       = out_item_r;
    out_item_valid_nxt = out_item_valid_r;
    out_last_nxt       = out_last_r;
    mem_req.wr_en      = 1'b0;
    mem_req.rd_en      = 1'b0;
    mem_req.wr_data    = in_value;
    mem_wr_addr        = idx_r;
    mem_rd_addr        = idx_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          case (in_cmd)
            CMD_APPEND: begin
              if (count_r == FULL_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                mem_req.wr_en = 1'b1;
                mem_wr_addr   = AW'(count_r);
                count_nxt     = count_r + CW'(1);
              end
              state_nxt = S_STATUS;
            end
            CMD_RM_HEAD: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_STATUS;
              end else begin
                count_nxt = count_r - CW'(1);
                idx_nxt   = '0;
                state_nxt = S_SHIFT_RD;
              end
            end
            CMD_RM_TAIL: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
              state_nxt = S_STATUS;
            end
            CMD_RM_POS: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_STATUS;
              end else if (!pos_ok) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_STATUS;
              end else begin
                count_nxt = count_r - CW'(1);
                idx_nxt   = AW'(in_position - POS_W'(1));
                state_nxt = S_SHIFT_RD;
              end
            end
            CMD_LIST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_STATUS;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_LIST_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (CW'(idx_r) < count_r) begin
          mem_req.rd_en = 1'b1;
          mem_rd_addr   = idx_r + AW'(1);
          state_nxt     = S_SHIFT_WR;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_SHIFT_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_data = mem_rd_data;
        mem_wr_addr     = idx_r;
        idx_nxt         = idx_r + AW'(1);
        state_nxt       = S_SHIFT_RD;
      end
      S_LIST_RD: begin
        mem_req.rd_en = 1'b1;
        mem_rd_addr   = idx_r;
        state_nxt     = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (can_emit) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = ST_OK;
          out_item_nxt       = mem_rd_data;
          out_item_valid_nxt = 1'b1;
          out_last_nxt       = list_last;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_LIST_RD;
          end
        end
      end
      S_STATUS: begin
        if (can_emit) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = status_r;
          out_item_nxt       = '0;
          out_item_valid_nxt = 1'b0;
          out_last_nxt       = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      count_r          <= count_nxt;
      idx_r            <= idx_nxt;
      status_r         <= status_nxt;
      out_valid_r      <= out_valid_nxt;
      out_status_r     <= out_status_nxt;
      out_item_r       <= out_item_nxt;
      out_item_valid_r <= out_item_valid_nxt;
      out_last_r       <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_item       = out_item_r;
  assign out_item_valid = out_item_valid_r;
  assign out_last       = out_last_r;

endmodule

FILE: hdl/ordered_list_store_top.sv
// Ordered list store: top level, sequencer plus entry memory.
// A status beat loads from S_STATUS once the output is free, then S_IDLE takes the next
// command. Removal at position p shifts each later entry down a slot, one memory read and
// write per shift. Listing delivers one beat per memory read then result load, holding
// while out_ready is low. Not ready while a command is in progress; reset (synchronous,
// rst_n low) empties the list and drops any pending result.
module ordered_list_store_top #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ols_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [ols_pkg::DATA_W-1:0]  in_value,
  input  logic [ols_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ols_pkg::STATUS_W-1:0]       out_status,
  output logic signed [ols_pkg::DATA_W-1:0]  out_item,
  output logic                               out_item_valid,
  output logic                               out_last
);
  import ols_pkg::*;

  localparam int AW = $clog2(DEPTH);

  mem_req_t          mem_req;
  logic [AW-1:0]     mem_wr_addr;
  logic [AW-1:0]     mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;

  ols_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_item      (out_item),
    .out_item_valid(out_item_valid),
    .out_last      (out_last),
    .mem_req       (mem_req),
    .mem_wr_addr   (mem_wr_addr),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  ols_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .req    (mem_req),
    .wr_addr(mem_wr_addr),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

FILE: hdl/ols_chk.sv
// Port-level checks for the ordered list store, bound to the top level.
// Depends on ols_pkg.
module ols_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [ols_pkg::CMD_W-1:0]          in_cmd,
  input logic signed [ols_pkg::DATA_W-1:0]  in_value,
  input logic [ols_pkg::POS_W-1:0]          in_position,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ols_pkg::STATUS_W-1:0]       out_status,
  input logic signed [ols_pkg::DATA_W-1:0]  out_item,
  input logic                               out_item_valid,
  input logic                               out_last
);
  import ols_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item) && $stable(out_status)
      && $stable(out_last) && $stable(out_item_valid))
    else $error("stalled result beat changed");

  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_valid |-> out_last && (out_item == '0))
    else $error("status beat must be last with zero item");

  a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_valid |-> out_status == ST_OK)
    else $error("listed element with non-ok status");

endmodule

bind ordered_list_store_top ols_chk u_ols_chk (.*);
